FILE: hdl/qsed_pkg.sv
`timescale 1ns / 1ps
// qsed_pkg: shared types and constants for the quoted string escape decoder.
// No dependencies; used by every qsed module and the top level.
package qsed_pkg;

   typedef enum logic [1:0] {
      KIND_CHAR     = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_TOO_LONG = 2'd2,
      KIND_UNTERM   = 2'd3
   } kind_type;

   localparam logic CSR_PROCESS_ESCAPES = 1'b0;
   localparam logic CSR_MAX_LENGTH      = 1'b1;

   localparam logic       PROCESS_ESCAPES_RESET = 1'b1;
   localparam logic [7:0] MAX_LENGTH_RESET      = 8'd80;
   localparam logic [7:0] LENGTH_SAT            = 8'hFF;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_BKSP      = 8'h08;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_FF        = 8'h0C;

   typedef struct packed {
      logic [7:0] out_char;
      kind_type   kind;
      logic [7:0] length;
      logic       last;
   } result_type;

   // One accepted byte yields at most one packet, holding one or two results.
   typedef struct packed {
      logic       pair;
      result_type res0;
      result_type res1;
   } packet_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == LENGTH_SAT) ? LENGTH_SAT : v + 8'd1;
   endfunction

endpackage

FILE: hdl/qsed_front.sv
`timescale 1ns / 1ps
// qsed_front: accepts raw bytes, runs the string/escape state machine and
// builds result packets. Holds the configuration registers. Uses qsed_pkg.
module qsed_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  end_of_line,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   output logic                  push,
   output qsed_pkg::packet_type  push_data
);

   typedef enum logic [1:0] {
      PH_SEEK = 2'd0,
      PH_IN   = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       esc_pend_ff, esc_pend_in;
   logic       oct_act_ff, oct_act_in;
   logic [7:0] oct_val_ff, oct_val_in;
   logic       prev_bs_ff, prev_bs_in;
   logic [7:0] count_ff, count_in;
   logic       process_escapes_ff;
   logic [7:0] max_length_ff;

   logic       esc, digit, closes, has_oct, has_chr, has_stat, stat_close;
   logic [7:0] chr_val, digit_val, len1, len2;
   qsed_pkg::result_type oct_res, chr_res, stat_res;

   always_comb begin
      esc        = process_escapes_ff;
      digit      = (in_byte >= qsed_pkg::CH_ZERO) && (in_byte <= qsed_pkg::CH_NINE);
      digit_val  = in_byte - qsed_pkg::CH_ZERO;
      closes     = (in_byte == qsed_pkg::CH_QUOTE) && !(esc && prev_bs_ff);
      phase_in   = phase_ff;
      esc_pend_in = esc_pend_ff;
      oct_act_in = oct_act_ff;
      oct_val_in = oct_val_ff;
      prev_bs_in = prev_bs_ff;
      has_oct    = 1'b0;
      has_chr    = 1'b0;
      has_stat   = 1'b0;
      stat_close = 1'b0;
      chr_val    = in_byte;

      case (phase_ff)
         PH_SEEK: begin
            if (in_byte == qsed_pkg::CH_QUOTE) phase_in = PH_IN;
            if (end_of_line) has_stat = 1'b1;
         end
         PH_IN: begin
            if (closes) begin
               has_oct    = esc && oct_act_ff;
               has_stat   = 1'b1;
               stat_close = 1'b1;
               phase_in   = PH_DONE;
            end else if (end_of_line) begin
               has_stat = 1'b1;
            end else if (esc) begin
               if (oct_act_ff && digit) begin
                  oct_val_in = {oct_val_ff[4:0], 3'b000} + digit_val;
                  prev_bs_in = 1'b0;
               end else begin
                  if (oct_act_ff) begin
                     has_oct    = 1'b1;
                     oct_act_in = 1'b0;
                     oct_val_in = 8'd0;
                  end
                  if (esc_pend_ff) begin
                     esc_pend_in = 1'b0;
                     case (in_byte)
                        qsed_pkg::CH_N: begin
                           has_chr = 1'b1;
                           chr_val = qsed_pkg::CH_LF;
                        end
                        qsed_pkg::CH_T: begin
                           has_chr = 1'b1;
                           chr_val = qsed_pkg::CH_TAB;
                        end
                        qsed_pkg::CH_B: begin
                           has_chr = 1'b1;
                           chr_val = qsed_pkg::CH_BKSP;
                        end
                        qsed_pkg::CH_R: begin
                           has_chr = 1'b1;
                           chr_val = qsed_pkg::CH_CR;
                        end
                        qsed_pkg::CH_F: begin
                           has_chr = 1'b1;
                           chr_val = qsed_pkg::CH_FF;
                        end
                        default: begin
                           if (digit) begin
                              oct_act_in = 1'b1;
                              oct_val_in = digit_val;
                           end else begin
                              has_chr = 1'b1;
                           end
                        end
                     endcase
                  end else if (in_byte == qsed_pkg::CH_BACKSLASH) begin
                     esc_pend_in = 1'b1;
                  end else begin
                     has_chr = 1'b1;
                  end
                  prev_bs_in = (in_byte == qsed_pkg::CH_BACKSLASH);
               end
            end else begin
               esc_pend_in = 1'b0;
               oct_act_in  = 1'b0;
               oct_val_in  = 8'd0;
               prev_bs_in  = 1'b0;
               has_chr     = 1'b1;
            end
         end
         default: ;
      endcase

      len1     = has_oct ? qsed_pkg::sat_inc(count_ff) : count_ff;
      len2     = has_chr ? qsed_pkg::sat_inc(len1) : len1;
      count_in = len2;

      if (end_of_line) begin
         phase_in    = PH_SEEK;
         esc_pend_in = 1'b0;
         oct_act_in  = 1'b0;
         oct_val_in  = 8'd0;
         prev_bs_in  = 1'b0;
         count_in    = 8'd0;
      end

      oct_res  = '{out_char: oct_val_ff, kind: qsed_pkg::KIND_CHAR, length: len1, last: 1'b0};
      chr_res  = '{out_char: chr_val, kind: qsed_pkg::KIND_CHAR, length: len2, last: 1'b0};
      stat_res = '{out_char: 8'd0, kind: qsed_pkg::KIND_UNTERM, length: len1, last: 1'b1};
      if (stat_close) begin
         stat_res.kind = (len1 >= max_length_ff) ? qsed_pkg::KIND_TOO_LONG
                                                 : qsed_pkg::KIND_DONE;
      end

      push_data.pair = has_oct && (has_chr || has_stat);
      push_data.res0 = has_oct ? oct_res : (has_chr ? chr_res : stat_res);
      push_data.res1 = has_chr ? chr_res : stat_res;
      push           = accept && (has_oct || has_chr || has_stat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_SEEK;
         esc_pend_ff        <= 1'b0;
         oct_act_ff         <= 1'b0;
         oct_val_ff         <= 8'd0;
         prev_bs_ff         <= 1'b0;
         count_ff           <= 8'd0;
         process_escapes_ff <= qsed_pkg::PROCESS_ESCAPES_RESET;
         max_length_ff      <= qsed_pkg::MAX_LENGTH_RESET;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            esc_pend_ff <= esc_pend_in;
            oct_act_ff  <= oct_act_in;
            oct_val_ff  <= oct_val_in;
            prev_bs_ff  <= prev_bs_in;
            count_ff    <= count_in;
         end
         if (csr_we) begin
            case (csr_index)
               qsed_pkg::CSR_PROCESS_ESCAPES: process_escapes_ff <= csr_wdata[0];
               qsed_pkg::CSR_MAX_LENGTH:      max_length_ff      <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: hdl/qsed_queue.sv
`timescale 1ns / 1ps
// qsed_queue: short FIFO of result packets between front and back ends.
// Uses qsed_pkg::packet_type.
module qsed_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qsed_pkg::packet_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output qsed_pkg::packet_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qsed_pkg::packet_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

endmodule

FILE: hdl/qsed_back.sv
`timescale 1ns / 1ps
// qsed_back: drains result packets one result per cycle, while the output is
// not stalled, into the output register. Uses qsed_pkg types.
module qsed_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  qsed_pkg::packet_type head,
   output logic                 pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output qsed_pkg::result_type rsp_res
);

   logic                 rsp_valid_ff;
   logic                 sel_ff;
   qsed_pkg::result_type res_ff;
   logic                 out_free, load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = out_free && !empty;
   assign pop       = load && (!head.pair || sel_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= !empty;
         if (load) sel_ff <= !pop;
      end
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= sel_ff ? head.res1 : head.res0;
   end

endmodule

FILE: hdl/quoted_string_escape_decoder_unit.sv
`timescale 1ns / 1ps
// Quoted string escape decoder, top level.
// Depends on qsed_pkg, qsed_front, qsed_queue and qsed_back.
// Usage:
//   req_*  : one raw byte of a configuration line per transaction, with
//            req_end_of_line on the final byte. Accepted when req_valid is
//            high and req_stall is low.
//   rsp_*  : decoded characters (kind 0) and one status per string or line
//            (kind 1 done, 2 too long, 3 unterminated, rsp_last set).
//   csr_*  : register writes (index 0 escape enable, 1 max length); always
//            ready, to be written only while the block is idle.
// Path: a byte's first result is written into the FIFO and then loaded into
// the output register; a second result of the same byte follows it out.
// Throughput: one byte per cycle while the FIFO is not full; the output
// register drains one result per cycle while rsp_stall is low, so a byte
// giving two results holds it for both. The packet FIFO (QUEUE_DEPTH) absorbs
// that and rsp_stall; req_stall rises only when the FIFO is full.
// Reset (synchronous): clears line state, empties the FIFO, drops rsp_valid
// and restores escape enable = 1, max length = 80.
// While rsp_stall is high the presented result holds and bytes keep being
// accepted until the FIFO fills.
module quoted_string_escape_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_length,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic                 accept, push, pop, full, empty;
   qsed_pkg::packet_type push_data, head;
   qsed_pkg::result_type rsp_res;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign csr_ready = 1'b1;

   qsed_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_line (req_end_of_line),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .push        (push),
      .push_data   (push_data)
   );

   qsed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   qsed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res)
   );

   assign rsp_out_char = rsp_res.out_char;
   assign rsp_kind     = rsp_res.kind;
   assign rsp_length   = rsp_res.length;
   assign rsp_last     = rsp_res.last;

endmodule

FILE: hdl/qsed_checker.sv
`timescale 1ns / 1ps
// qsed_checker: port-level assertions for the decoder top level, bound to
// quoted_string_escape_decoder_unit. Uses qsed_pkg kind codes.
module qsed_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_length,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_kind)
         && $stable(rsp_length) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != qsed_pkg::KIND_CHAR)))
      else $error("last flag disagrees with result kind");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != qsed_pkg::KIND_CHAR |-> rsp_out_char == 8'd0)
      else $error("status result carries a character");

   a_char_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == qsed_pkg::KIND_CHAR |-> rsp_length != 8'd0)
      else $error("character result with zero length");

endmodule

bind quoted_string_escape_decoder_unit qsed_checker u_qsed_checker (.*);

FILE: tb/tb_quoted_string_escape_decoder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for quoted_string_escape_decoder_unit: directed and random
// configuration lines, a byte-level decode model and an in-order result check.
// Depends on qsed_pkg and the quoted_string_escape_decoder_unit RTL.
module tb_quoted_string_escape_decoder_unit;

   typedef enum logic [1:0] {
      PH_SEEK      = 2'd0,
      PH_IN_STRING = 2'd1,
      PH_DONE      = 2'd2
   } line_phase_type;

   typedef struct packed {
      logic [7:0] value;
      logic       eol;
   } line_byte_type;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte     = 8'd0;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_out_char;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_length;
   logic       rsp_last;
   logic       csr_valid       = 1'b0;
   logic       csr_ready;
   logic       csr_index       = 1'b0;
   logic [7:0] csr_wdata       = 8'd0;

   quoted_string_escape_decoder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_kind        (rsp_kind),
      .rsp_length      (rsp_length),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   line_byte_type         line_bytes[$];
   qsed_pkg::result_type  decoded_backlog[$];

   // decoder model state
   logic           cfg_escapes    = qsed_pkg::PROCESS_ESCAPES_RESET;
   logic [7:0]     cfg_max_length = qsed_pkg::MAX_LENGTH_RESET;
   line_phase_type ln_phase       = PH_SEEK;
   logic           esc_pending    = 1'b0;
   logic           oct_active     = 1'b0;
   logic [7:0]     oct_value      = 8'd0;
   logic           prev_backslash = 1'b0;
   logic [7:0]     char_count     = 8'd0;

   int errors         = 0;
   int cycle_no       = 0;
   int quiet_cycles   = 0;
   int bytes_queued   = 0;
   int lines_queued   = 0;
   int settings_used  = 0;
   int chars_checked  = 0;
   int status_checked = 0;

   function automatic bit is_digit(input logic [7:0] c);
      return c >= qsed_pkg::CH_ZERO && c <= qsed_pkg::CH_NINE;
   endfunction

   // random idling, switched off for one long stretch in every three of equal length
   function automatic logic take_gap();
      if (((cycle_no / 1000) % 3) == 1) return 1'b0;
      return $urandom_range(0, 99) < 10;
   endfunction

   task automatic emit(input logic [7:0] ch, input qsed_pkg::kind_type k);
      qsed_pkg::result_type r;
      r.out_char = ch;
      r.kind     = k;
      r.length   = char_count;
      r.last     = (k != qsed_pkg::KIND_CHAR);
      decoded_backlog.push_back(r);
   endtask

   task automatic emit_char(input logic [7:0] ch);
      if (char_count != qsed_pkg::LENGTH_SAT) char_count = char_count + 8'd1;
      emit(ch, qsed_pkg::KIND_CHAR);
   endtask

   task automatic clear_line();
      ln_phase       = PH_SEEK;
      esc_pending    = 1'b0;
      oct_active     = 1'b0;
      oct_value      = 8'd0;
      prev_backslash = 1'b0;
      char_count     = 8'd0;
   endtask

   task automatic decode_escaped(input logic [7:0] c);
      if (oct_active) begin
         if (is_digit(c)) begin
            oct_value      = {oct_value[4:0], 3'b000} + (c - qsed_pkg::CH_ZERO);
            prev_backslash = 1'b0;
            return;
         end
         emit_char(oct_value);
         oct_active = 1'b0;
         oct_value  = 8'd0;
      end
      if (esc_pending) begin
         esc_pending = 1'b0;
         case (c)
            qsed_pkg::CH_N: emit_char(qsed_pkg::CH_LF);
            qsed_pkg::CH_T: emit_char(qsed_pkg::CH_TAB);
            qsed_pkg::CH_B: emit_char(qsed_pkg::CH_BKSP);
            qsed_pkg::CH_R: emit_char(qsed_pkg::CH_CR);
            qsed_pkg::CH_F: emit_char(qsed_pkg::CH_FF);
            default: begin
               if (is_digit(c)) begin
                  oct_active = 1'b1;
                  oct_value  = c - qsed_pkg::CH_ZERO;
               end else begin
                  emit_char(c);
               end
            end
         endcase
      end else if (c == qsed_pkg::CH_BACKSLASH) begin
         esc_pending = 1'b1;
      end else begin
         emit_char(c);
      end
      prev_backslash = (c == qsed_pkg::CH_BACKSLASH);
   endtask

   task automatic decode_line_byte(input logic [7:0] c, input logic eol);
      logic closes;
      logic open_at_end;
      open_at_end = 1'b0;
      case (ln_phase)
         PH_SEEK: begin
            if (c == qsed_pkg::CH_QUOTE) ln_phase = PH_IN_STRING;
            open_at_end = 1'b1;
         end
         PH_IN_STRING: begin
            closes = (c == qsed_pkg::CH_QUOTE) && !(cfg_escapes && prev_backslash);
            if (closes) begin
               if (cfg_escapes && oct_active) emit_char(oct_value);
               emit(8'd0, (char_count >= cfg_max_length) ? qsed_pkg::KIND_TOO_LONG
                                                         : qsed_pkg::KIND_DONE);
               ln_phase = PH_DONE;
            end else if (eol) begin
               open_at_end = 1'b1;
            end else if (cfg_escapes) begin
               decode_escaped(c);
            end else begin
               esc_pending    = 1'b0;
               oct_active     = 1'b0;
               oct_value      = 8'd0;
               prev_backslash = 1'b0;
               emit_char(c);
            end
         end
         default: ;
      endcase
      if (eol) begin
         if (open_at_end) emit(8'd0, qsed_pkg::KIND_UNTERM);
         clear_line();
      end
   endtask

   // byte driver
   always @(posedge clock) begin : drive_bytes
      logic accepted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            decode_line_byte(req_in_byte, req_end_of_line);
            void'(line_bytes.pop_front());
         end
         if (req_valid && !accepted) begin
            // stalled: hold the transaction
         end else if (line_bytes.size() != 0 && !take_gap()) begin
            req_valid       <= 1'b1;
            req_in_byte     <= line_bytes[0].value;
            req_end_of_line <= line_bytes[0].eol;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin : check_results
      qsed_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_backlog.size() == 0) begin
               $error("unexpected result: char %0d kind %0d length %0d last %0d",
                      rsp_out_char, rsp_kind, rsp_length, rsp_last);
               errors++;
            end else begin
               want = decoded_backlog.pop_front();
               check_field("out_char", want.out_char, rsp_out_char);
               check_field("kind", want.kind, rsp_kind);
               check_field("length", want.length, rsp_length);
               check_field("last", want.last, rsp_last);
               if (want.kind == qsed_pkg::KIND_CHAR) chars_checked++;
               else status_checked++;
            end
         end
         rsp_stall <= take_gap();
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_no <= cycle_no + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("tb_quoted_string_escape_decoder_unit: FAIL");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      line_byte_type t;
      t.value = b;
      t.eol   = 1'b0;
      line_bytes.push_back(t);
      bytes_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic end_line();
      line_byte_type t;
      t     = line_bytes.pop_back();
      t.eol = 1'b1;
      line_bytes.push_back(t);
      lines_queued++;
   endtask

   task automatic wait_drained();
      while (line_bytes.size() != 0 || decoded_backlog.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == qsed_pkg::CSR_PROCESS_ESCAPES) cfg_escapes = val[0];
      else cfg_max_length = val;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == qsed_pkg::CH_QUOTE || b == qsed_pkg::CH_BACKSLASH) b = qsed_pkg::CH_ZERO;
      return b;
   endfunction

   task automatic queue_random_line(input bit long_lines);
      int unsigned n;
      int unsigned ntok;
      int unsigned ending;
      if ($urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 8);
         repeat (n) push_byte(8'($urandom_range(0, 255)));
         end_line();
         return;
      end
      n = $urandom_range(0, 2);
      repeat (n) push_byte(plain_byte());
      push_byte(qsed_pkg::CH_QUOTE);
      ntok = (long_lines && $urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(0, 8);
      repeat (ntok) begin
         case ($urandom_range(0, 8))
            0, 1, 2, 3: push_byte(plain_byte());
            4: begin
               push_byte(qsed_pkg::CH_BACKSLASH);
               case ($urandom_range(0, 4))
                  0: push_byte(qsed_pkg::CH_N);
                  1: push_byte(qsed_pkg::CH_T);
                  2: push_byte(qsed_pkg::CH_B);
                  3: push_byte(qsed_pkg::CH_R);
                  default: push_byte(qsed_pkg::CH_F);
               endcase
            end
            5: begin
               push_byte(qsed_pkg::CH_BACKSLASH);
               push_byte($urandom_range(0, 1) ? qsed_pkg::CH_QUOTE : qsed_pkg::CH_BACKSLASH);
            end
            6, 7: begin
               push_byte(qsed_pkg::CH_BACKSLASH);
               repeat ($urandom_range(1, 4))
                  push_byte(8'(qsed_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            default: begin
               push_byte(qsed_pkg::CH_BACKSLASH);
               push_byte(8'($urandom_range(0, 255)));
            end
         endcase
      end
      ending = $urandom_range(0, 9);
      if (ending < 7) begin
         push_byte(qsed_pkg::CH_QUOTE);
         repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
      end else if (ending < 9) begin
         push_byte(8'($urandom_range(0, 255)));
      end else begin
         push_byte(qsed_pkg::CH_BACKSLASH);
         push_byte(8'($urandom_range(0, 255)));
      end
      end_line();
   endtask

   task automatic run_phase(input logic esc, input logic [7:0] maxl,
                            input bit long_lines, input int nbytes);
      int start;
      wait_drained();
      write_reg(qsed_pkg::CSR_PROCESS_ESCAPES, {7'd0, esc});
      write_reg(qsed_pkg::CSR_MAX_LENGTH, maxl);
      settings_used++;
      start = bytes_queued;
      if (long_lines) begin
         // long enough to saturate the length count
         push_byte(qsed_pkg::CH_QUOTE);
         for (int i = 0; i < 300; i++) push_byte(8'(8'h61 + (i % 26)));
         push_byte(qsed_pkg::CH_QUOTE);
         end_line();
      end
      while (bytes_queued - start < nbytes) queue_random_line(long_lines);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // every escape letter, closing quote on the final byte
      push_text("\"\\n\\t\\b\\r\\f\"");
      end_line();
      // quote after escaped backslash, digit run with 9, digits ended by quote,
      // bytes after the closing quote
      push_text("\"\\\\\"\\19z\\101\"\"");
      end_line();
      // no quote at the start of the line, then unterminated with a pending escape
      push_byte(8'h00);
      push_text("\"ab\\");
      push_byte(8'hFF);
      end_line();

      // escapes switched off while a digit value is pending
      wait_drained();
      push_text("\"a\\12");
      wait_drained();
      write_reg(qsed_pkg::CSR_PROCESS_ESCAPES, 8'd0);
      settings_used++;
      push_text("3\\\"x");
      end_line();

      run_phase(1'b1, 8'd1, 1'b0, 350);
      run_phase(1'b0, 8'd255, 1'b0, 350);
      run_phase(1'b1, 8'd255, 1'b1, 350);
      run_phase(1'b1, 8'($urandom_range(2, 30)), 1'b0, 350);
      run_phase(1'b0, 8'($urandom_range(1, 10)), 1'b0, 350);
      run_phase(1'b1, 8'd80, 1'b1, 350);

      wait_drained();
      $display("%0d bytes in %0d lines over %0d register settings", bytes_queued,
               lines_queued, settings_used);
      $display("%0d characters and %0d status results compared", chars_checked,
               status_checked);
      if (errors == 0 && decoded_backlog.size() == 0) begin
         $display("tb_quoted_string_escape_decoder_unit: PASS");
      end else begin
         $display("tb_quoted_string_escape_decoder_unit: FAIL");
      end
      $finish;
   end

endmodule
